FILE: rtl/hpat_pkg.sv
// Package for the hall period and angle tracker.
// Holds the sequencer state type, register indexes, event kinds and reset values.
// No dependencies.
`timescale 1ns / 1ps

package hpat_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  localparam int COLS_W    = 13;
  localparam int COL_OUT_W = 12;
  localparam int RPM_W     = 24;
  localparam int RATE_W    = 28;
  localparam int NUM_W     = RATE_W + 6;
  localparam int RPT_W     = 16;

  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_TICK_RATE    = 1'b1;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [COLS_W-1:0] COLS_RESET = 13'd720;
  localparam logic [RATE_W-1:0] RATE_RESET = 28'd1000000;
  localparam logic [RPT_W-1:0]  NONE_REPORTED = 16'hFFFF;

endpackage

FILE: rtl/hall_period_angle_tracker.sv
// Hall period and angle tracker: rpm from capture spacing, display column from tick time.
// One shared subtractor runs a restoring divider under a small sequencer.
// Depends on hpat_pkg.
// Sequence: an accepted beat passes S_PREP, then, if it needs a division, S_MUL and the
// restoring divider S_DIV over a DW-bit dividend (DW = max(34, STAMP_BITS+13)), then S_FIN.
// One beat is in the sequencer at a time; the next is taken only back in S_IDLE.
// A new beat is taken while the previous result still waits in the output register.
// Reset: synchronous; registers return to 720 columns and 1 MHz, all tracking state clears.
`timescale 1ns / 1ps

module hall_period_angle_tracker #(
  parameter int MAX_COLUMNS = 4096,
  parameter int STAMP_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] timestamp
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [11:0] column, [35:12] rpm, [36] period_known,
                                 // [37] new_column, [39:38] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import hpat_pkg::*;

  localparam int SB    = STAMP_BITS;
  localparam int DW    = (SB + COLS_W > NUM_W) ? SB + COLS_W : NUM_W;
  localparam int CNT_W = $clog2(DW);

  // configuration
  logic [COLS_W-1:0] column_count;
  logic [RATE_W-1:0] tick_rate_hz;

  // tracking state
  logic [SB-1:0]     previous_capture;
  logic              capture_seen;
  logic [SB-1:0]     revolution_period;
  logic [RPM_W-1:0]  rpm_value;
  logic [COLS_W-1:0] current_col;
  logic [RPT_W-1:0]  reported_col;

  // sequencer and datapath
  state_t            state, state_next;
  logic              op_q;
  logic [SB-1:0]     stamp_q;
  logic [SB-1:0]     span;
  logic [SB-1:0]     divisor;
  logic [SB-1:0]     rem;
  logic [DW-1:0]     dq;
  logic [CNT_W-1:0]  cnt;
  logic              run_div;
  logic              late;

  logic [COLS_W-1:0] cols;
  logic [SB-1:0]     span_w;
  logic              go_div;
  logic              fin_go;
  logic [SB:0]       rem_sh;
  logic [SB:0]       sub;
  logic              ge;
  logic [NUM_W-1:0]  num60;
  logic [SB+COLS_W-1:0] prod;
  logic [RPM_W-1:0]  rpm_sat;
  logic [SB-1:0]     period_n;
  logic [RPM_W-1:0]  rpm_n;
  logic [COLS_W-1:0] col_n;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_COLUMN_COUNT: prdata = {{(32-COLS_W){1'b0}}, column_count};
      REG_TICK_RATE:    prdata = {{(32-RATE_W){1'b0}}, tick_rate_hz};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= COLS_RESET;
      tick_rate_hz <= RATE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_COLUMN_COUNT: column_count <= pwdata[COLS_W-1:0];
        REG_TICK_RATE:    tick_rate_hz <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the column count into 1..MAX_COLUMNS
  always_comb begin
    if (column_count == '0) begin
      cols = COLS_W'(1);
    end else if ({{(32-COLS_W){1'b0}}, column_count} > 32'(MAX_COLUMNS)) begin
      cols = COLS_W'(MAX_COLUMNS);
    end else begin
      cols = column_count;
    end
  end

  assign span_w = stamp_q - previous_capture;

  always_comb begin
    if (op_q == OP_CAPTURE) begin
      go_div = capture_seen && (span_w != '0);
    end else begin
      go_div = (revolution_period != '0) && (span_w < revolution_period);
    end
  end

  // shared subtract unit: one restoring division step
  assign rem_sh = {rem, dq[DW-1]};
  assign sub    = rem_sh - {1'b0, divisor};
  assign ge     = !sub[SB];

  assign num60 = ({{6{1'b0}}, tick_rate_hz} << 6) - ({{6{1'b0}}, tick_rate_hz} << 2);
  assign prod  = span * cols;
  assign rpm_sat = (|dq[DW-1:RPM_W]) ? {RPM_W{1'b1}} : dq[RPM_W-1:0];

  // result of the beat in hand
  always_comb begin
    period_n = revolution_period;
    rpm_n    = rpm_value;
    col_n    = current_col;
    if (op_q == OP_CAPTURE) begin
      if (run_div) begin
        period_n = divisor;
        rpm_n    = rpm_sat;
      end
      if (run_div || revolution_period != '0) begin
        col_n = '0;
      end
    end else if (late) begin
      col_n = cols - COLS_W'(1);
    end else if (run_div) begin
      col_n = dq[COLS_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_PREP;
      S_PREP: state_next = go_div ? S_MUL : S_FIN;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (cnt == CNT_W'(DW - 1)) state_next = S_FIN;
      S_FIN:  if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
    fin_go   = (state == S_FIN) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      previous_capture  <= '0;
      capture_seen      <= 1'b0;
      revolution_period <= '0;
      rpm_value         <= '0;
      current_col       <= '0;
      reported_col      <= NONE_REPORTED;
      m_tvalid          <= 1'b0;
      run_div           <= 1'b0;
      late              <= 1'b0;
      cnt               <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q    <= s_tuser;
            stamp_q <= s_tdata[SB-1:0];
          end
        end
        S_PREP: begin
          span    <= span_w;
          run_div <= go_div;
          late    <= (op_q == OP_TICK) && (revolution_period != '0) &&
                     (span_w >= revolution_period);
          divisor <= (op_q == OP_CAPTURE) ? span_w : revolution_period;
        end
        S_MUL: begin
          dq  <= (op_q == OP_CAPTURE) ? DW'(num60) : DW'(prod);
          rem <= '0;
          cnt <= '0;
        end
        S_DIV: begin
          rem <= ge ? sub[SB-1:0] : rem_sh[SB-1:0];
          dq  <= {dq[DW-2:0], ge};
          cnt <= cnt + CNT_W'(1);
        end
        S_FIN: begin
          if (fin_go) begin
            if (op_q == OP_CAPTURE) begin
              previous_capture <= stamp_q;
              capture_seen     <= 1'b1;
            end
            revolution_period <= period_n;
            rpm_value         <= rpm_n;
            current_col       <= col_n;
            reported_col      <= RPT_W'(col_n);
            m_tdata <= {2'b00, RPT_W'(col_n) != reported_col, period_n != '0,
                        rpm_n, col_n[COL_OUT_W-1:0]};
          end
        end
        default: ;
      endcase
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  a_period_needs_capture: assert property (@(posedge clk) disable iff (rst)
    (revolution_period != '0) |-> capture_seen)
    else $error("period known without a capture");

  a_accept_starts_prep: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_PREP))
    else $error("accepted beat did not start the sequencer");

  a_late_excludes_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> !(run_div && late))
    else $error("late column and division both chosen");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for hall_period_angle_tracker: a directed table, then random
// capture/tick sequences under several register settings, checked against a local predictor.
// Depends on hpat_pkg and the hall_period_angle_tracker RTL.
`timescale 1ns / 1ps

module tb;
  import hpat_pkg::*;

  localparam int MAX_COLS = 4096;
  localparam logic [2:0] ADDR_COLS = {REG_COLUMN_COUNT, 2'b00};
  localparam logic [2:0] ADDR_RATE = {REG_TICK_RATE, 2'b00};

  typedef struct packed {
    logic [11:0] column;
    logic [23:0] rpm;
    logic        period_known;
    logic        new_column;
  } reading_t;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  addr;
    logic        op;
    logic        rel;
    logic [31:0] val;
    logic        typed;
    reading_t    want;
  } step_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;  // [31:0] timestamp
  logic        s_tuser  = 1'b0; // [0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [11:0] column, [35:12] rpm, [36] period_known,
                               // [37] new_column, [39:38] zero
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  hall_period_angle_tracker DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [12:0] cfg_cols;
  logic [27:0] cfg_rate;
  logic [31:0] capture_stamp;
  logic        capture_seen;
  logic [31:0] rev_period;
  logic [23:0] rpm_now;
  logic [11:0] col_now;
  logic [15:0] col_reported;

  reading_t readings_due [$];
  step_t    script [$];
  int       events_sent   = 0;
  int       readings_seen = 0;
  int       faults        = 0;
  int       reg_writes    = 0;
  int       burst_left    = 0;
  int       hold_left     = 0;
  int       hold_mark     = -1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic reading_t track_event(logic op, logic [31:0] ts);
    logic [31:0] diff;
    logic [31:0] elapsed;
    logic [63:0] quot;
    logic [12:0] eff;
    reading_t    r;
    if (op == OP_CAPTURE) begin
      if (capture_seen) begin
        diff = ts - capture_stamp;
        if (diff != 0) begin
          quot = (64'd60 * cfg_rate) / diff;
          rev_period = diff;
          rpm_now = (quot > 64'hFFFFFF) ? 24'hFFFFFF : quot[23:0];
        end
      end
      capture_seen = 1'b1;
      capture_stamp = ts;
    end
    if (rev_period != 0) begin
      eff = (cfg_cols == 0) ? 13'd1 : (cfg_cols > MAX_COLS) ? 13'(MAX_COLS) : cfg_cols;
      elapsed = ts - capture_stamp;
      quot = (64'(elapsed) * eff) / rev_period;
      if (quot >= eff) quot = 64'(eff - 13'd1);
      col_now = quot[11:0];
    end
    r.column       = col_now;
    r.rpm          = rpm_now;
    r.period_known = (rev_period != 0);
    r.new_column   = ({4'b0, col_now} != col_reported);
    col_reported   = {4'b0, col_now};
    return r;
  endfunction

  function automatic step_t ev(logic op, logic rel, logic [31:0] val, logic typed,
                               logic [11:0] c, logic [23:0] r, logic pk, logic nc);
    step_t s;
    s = '0;
    s.op = op;
    s.rel = rel;
    s.val = val;
    s.typed = typed;
    s.want = '{c, r, pk, nc};
    return s;
  endfunction

  function automatic step_t reg_step(logic [2:0] addr, logic [31:0] val);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.addr = addr;
    s.val = val;
    return s;
  endfunction

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 64);
      1:       return $urandom_range(100, 5000);
      2:       return $urandom_range(10000, 2000000);
      default: return ($urandom >> 1) | 32'd1;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    s_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_COLS) cfg_cols = val[12:0];
    else if (addr == ADDR_RATE) cfg_rate = val[27:0];
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // bursts of beats with random gaps, some bursts back to back
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 70)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send(logic op, logic [31:0] ts, logic typed, reading_t want);
    reading_t got;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= ts;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    got = track_event(op, ts);
    readings_due.push_back(typed ? want : got);
    events_sent++;
  endtask

  task automatic run_phase(int n);
    int          k;
    int          r;
    int          ticks_left;
    logic [31:0] span;
    logic [31:0] ts;
    logic        op;
    span = pick_span();
    ticks_left = 0;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 2) span = pick_span();
      if (r < 10) begin
        op = 1'($urandom_range(0, 1));
        ts = $urandom;
      end else if (r < 14) begin
        op = OP_CAPTURE;
        ts = capture_stamp;
      end else if (ticks_left == 0) begin
        op = OP_CAPTURE;
        ts = capture_stamp + span - span / 16 + $urandom_range(0, span / 8);
        ticks_left = $urandom_range(0, 8);
      end else begin
        op = OP_TICK;
        ts = capture_stamp + $urandom_range(0, span + span / 4);
        ticks_left--;
      end
      pace();
      send(op, ts, 1'b0, '0);
    end
  endtask

  task automatic note_fault(string what, reading_t want, reading_t act);
    if (faults < 10)
      $display("%0t %s: col %0d/%0d rpm %0d/%0d known %0b/%0b new %0b/%0b (exp/act)",
               $realtime, what, want.column, act.column, want.rpm, act.rpm,
               want.period_known, act.period_known, want.new_column, act.new_column);
    faults++;
  endtask

  // receiver: stall pattern in modes, plus two long hold-offs
  always @(posedge clk) begin
    int       mode_left;
    int       mode;
    reading_t act;
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      act = '{m_tdata[11:0], m_tdata[35:12], m_tdata[36], m_tdata[37]};
      if (readings_due.size() == 0) begin
        note_fault("unexpected beat", '0, act);
      end else begin
        want = readings_due.pop_front();
        if (act != want) note_fault("mismatch", want, act);
      end
      readings_seen++;
    end
    if (hold_left == 0 && (readings_seen == 400 || readings_seen == 1100) &&
        hold_mark != readings_seen) begin
      hold_mark = readings_seen;
      hold_left = 700;
    end
    if (mode_left == 0) begin
      mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
    end
    mode_left--;
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) >= mode);
    end
  end

  initial begin
    int          ph;
    int          guard;
    logic [31:0] ts;
    cfg_cols      = COLS_RESET;
    cfg_rate      = RATE_RESET;
    capture_stamp = '0;
    capture_seen  = 1'b0;
    rev_period    = '0;
    rpm_now       = '0;
    col_now       = '0;
    col_reported  = NONE_REPORTED;

    script.push_back(ev(OP_TICK,    1'b0, 32'h0,        1'b1, 12'd0,   24'd0,      1'b0, 1'b1));
    script.push_back(ev(OP_TICK,    1'b0, 32'hFFFFFFFF, 1'b1, 12'd0,   24'd0,      1'b0, 1'b0));
    script.push_back(ev(OP_CAPTURE, 1'b0, 32'hFFFFFFF0, 1'b1, 12'd0,   24'd0,      1'b0, 1'b0));
    script.push_back(ev(OP_CAPTURE, 1'b0, 32'hFFFFFFF0, 1'b1, 12'd0,   24'd0,      1'b0, 1'b0));
    script.push_back(ev(OP_CAPTURE, 1'b0, 32'h000F4230, 1'b1, 12'd0,   24'd60,     1'b1, 1'b0));
    script.push_back(ev(OP_TICK,    1'b1, 32'd500000,   1'b1, 12'd360, 24'd60,     1'b1, 1'b1));
    script.push_back(ev(OP_TICK,    1'b1, 32'd500000,   1'b1, 12'd360, 24'd60,     1'b1, 1'b0));
    script.push_back(ev(OP_TICK,    1'b1, 32'd999999,   1'b1, 12'd719, 24'd60,     1'b1, 1'b1));
    script.push_back(ev(OP_TICK,    1'b1, 32'd3000000,  1'b1, 12'd719, 24'd60,     1'b1, 1'b0));
    script.push_back(ev(OP_TICK,    1'b1, 32'hFFFFFFFF, 1'b1, 12'd719, 24'd60,     1'b1, 1'b0));
    script.push_back(ev(OP_CAPTURE, 1'b1, 32'd1,        1'b1, 12'd0,   24'hFFFFFF, 1'b1, 1'b1));
    script.push_back(ev(OP_TICK,    1'b1, 32'd0,        1'b1, 12'd0,   24'hFFFFFF, 1'b1, 1'b0));
    script.push_back(reg_step(ADDR_COLS, 32'd0));
    script.push_back(ev(OP_TICK,    1'b1, 32'd5,        1'b1, 12'd0,   24'hFFFFFF, 1'b1, 1'b0));
    script.push_back(ev(OP_CAPTURE, 1'b1, 32'h7FFFFFFF, 1'b1, 12'd0,   24'd0,      1'b1, 1'b0));
    script.push_back(reg_step(ADDR_COLS, 32'd8191));
    script.push_back(ev(OP_TICK,    1'b1, 32'h40000000, 1'b0, '0, '0, 1'b0, 1'b0));
    script.push_back(ev(OP_TICK,    1'b1, 32'h7FFFFFFE, 1'b0, '0, '0, 1'b0, 1'b0));
    script.push_back(reg_step(ADDR_RATE, 32'd0));
    script.push_back(ev(OP_CAPTURE, 1'b1, 32'd1000,     1'b1, 12'd0,   24'd0,      1'b1, 1'b1));
    script.push_back(reg_step(ADDR_RATE, 32'h0FFFFFFF));
    script.push_back(ev(OP_CAPTURE, 1'b1, 32'hFFFFFFFF, 1'b1, 12'd0,   24'd3,      1'b1, 1'b0));
    script.push_back(ev(OP_CAPTURE, 1'b1, 32'd100,      1'b1, 12'd0,   24'hFFFFFF, 1'b1, 1'b0));
    script.push_back(reg_step(ADDR_COLS, 32'd4096));
    script.push_back(ev(OP_TICK,    1'b1, 32'd99,       1'b0, '0, '0, 1'b0, 1'b0));
    script.push_back(ev(OP_TICK,    1'b1, 32'd50,       1'b0, '0, '0, 1'b0, 1'b0));
    script.push_back(reg_step(ADDR_COLS, 32'd720));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_reg(script[i].addr, script[i].val);
      end else begin
        ts = script[i].rel ? capture_stamp + script[i].val : script[i].val;
        pace();
        send(script[i].op, ts, script[i].typed, script[i].want);
      end
    end

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(ADDR_COLS, 32'd1);
          write_reg(ADDR_RATE, 32'h0FFFFFFF);
        end
        1: begin
          write_reg(ADDR_COLS, 32'd4096);
          write_reg(ADDR_RATE, 32'd1);
        end
        2: begin
          write_reg(ADDR_COLS, 32'd0);
          write_reg(ADDR_RATE, 32'd200000000);
        end
        3: begin
          write_reg(ADDR_COLS, 32'd8191);
          write_reg(ADDR_RATE, 32'd0);
        end
        default: begin
          write_reg(ADDR_COLS, $urandom_range(1, 4096));
          write_reg(ADDR_RATE, $urandom_range(1, 200000000));
        end
      endcase
      run_phase(258);
    end

    s_tvalid <= 1'b0;
    for (guard = 0; readings_due.size() != 0 && guard < 20000; guard++) @(posedge clk);
    repeat (60) @(posedge clk);
    if (readings_due.size() != 0) begin
      $display("%0d readings never arrived", readings_due.size());
      faults++;
    end

    $display("Covered %0d capture/tick beats and %0d readings over %0d register writes,",
             events_sent, readings_seen, reg_writes);
    $display("including column count and tick rate extremes and two long output hold-offs.");
    if (faults == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/hpat_pkg.sv
rtl/hall_period_angle_tracker.sv
dv/tb.sv
